[sv/tcw_pkg.sv]
// shared types, constants and helpers for the text console writer
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int FUNC_W = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ATTR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;

   // character codes and reset values
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // function codes on the request stream
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_SET   = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // classified operations handed to the back end
   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_SET,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } cmd_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [ROW_W-1:0]  cursor_y;
      logic [COL_W-1:0]  cursor_x;
   } rsp_type;

   // linear cell address of a column and row
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(row) * ADDR_W'(COLUMNS);
      return base + ADDR_W'(col);
   endfunction

endpackage
`default_nettype wire

[sv/tcw_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[sv/tcw_front.sv]
// request intake: decode, saturate and queue commands for the back end
`timescale 1ns / 1ps
`default_nettype none
module tcw_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [tcw_pkg::FUNC_W-1:0] in_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0] in_char,
   input  wire logic [tcw_pkg::COL_W-1:0]  in_col,
   input  wire logic [tcw_pkg::ROW_W-1:0]  in_row,
   output logic                        cmd_valid,
   output tcw_pkg::cmd_type            cmd,
   input  wire logic                   cmd_pop
);
   import tcw_pkg::*;

   cmd_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   cmd_type               cls;
   logic                  push;
   logic                  col_ok, row_ok;

   // classify the incoming beat
   always_comb begin
      col_ok        = int'(in_col) < COLUMNS;
      row_ok        = int'(in_row) < ROWS;
      cls.char_code = in_char;
      cls.col       = '0;
      cls.row       = '0;
      cls.op        = OP_NOP;
      unique case (func_type'(in_func))
         FUNC_PUT: begin
            cls.op = (in_char == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
         end
         FUNC_CLEAR: begin
            cls.op = OP_CLEAR;
         end
         FUNC_SET: begin
            cls.op  = OP_SET;
            cls.col = col_ok ? in_col : COL_W'(COLUMNS - 1);
            cls.row = row_ok ? in_row : ROW_W'(ROWS - 1);
         end
         FUNC_READ: begin
            if (col_ok && row_ok) begin
               cls.op  = OP_READ;
               cls.col = in_col;
               cls.row = in_row;
            end
         end
         default: begin
            cls.op = OP_NOP;
         end
      endcase
   end

   // queue bookkeeping
   assign in_ready  = count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign push      = in_valid && in_ready;
   assign cmd_valid = count_ff != '0;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (cmd_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

[sv/tcw_back.sv]
// command sequencer: cursor, screen store sweeps and result register
`timescale 1ns / 1ps
`default_nettype none
module tcw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_valid,
   input  wire tcw_pkg::cmd_type           cmd,
   output logic                            cmd_pop,
   input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output tcw_pkg::rsp_type                rsp
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_SCROLL,
      S_FILL
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] cnt_ff;
   logic [COL_W-1:0]  cur_col_ff;
   logic [ROW_W-1:0]  cur_row_ff;
   logic              wr_pend_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [CELL_W-1:0] fill_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              slot_free;
   logic              wrap, at_bottom, need_scroll;
   logic [COL_W-1:0]  adv_col;
   logic [ROW_W-1:0]  adv_row;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid && slot_free;

   // cursor advance for put char and newline
   always_comb begin
      wrap        = (cmd.op == OP_NEWLINE) || (cur_col_ff == COL_W'(COLUMNS - 1));
      at_bottom   = cur_row_ff == ROW_W'(ROWS - 1);
      adv_col     = wrap ? '0 : cur_col_ff + 1'b1;
      adv_row     = (wrap && !at_bottom) ? cur_row_ff + 1'b1 : cur_row_ff;
      need_scroll = wrap && at_bottom;
   end

   // screen store port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = cell_addr(cmd.row, cmd.col);
      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
         end
         S_IDLE: begin
            ram_we    = cmd_pop && (cmd.op == OP_PUT);
            ram_waddr = cell_addr(cur_row_ff, cur_col_ff);
            ram_wdata = {attr, cmd.char_code};
         end
         S_READ: begin
            ram_we = 1'b0;
         end
         S_SCROLL: begin
            ram_raddr = cnt_ff + ADDR_W'(COLUMNS);
            ram_we    = wr_pend_ff;
            ram_waddr = wr_addr_ff;
            ram_wdata = ram_rdata;
         end
         S_FILL: begin
            ram_we = 1'b1;
            if (wr_pend_ff) begin
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end else begin
               ram_waddr = cnt_ff;
               ram_wdata = fill_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer state, cursor and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a pop always frees the slot, so the pop branch settles the valid flag itself
         if (rsp_valid_ff && rsp_ready && !cmd_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (cmd_pop) begin
                  unique case (cmd.op)
                     OP_PUT, OP_NEWLINE: begin
                        cur_col_ff <= adv_col;
                        cur_row_ff <= adv_row;
                        if (need_scroll) begin
                           rsp_valid_ff <= 1'b0;
                           cnt_ff       <= '0;
                           state_ff     <= S_SCROLL;
                        end else begin
                           rsp_valid_ff     <= 1'b1;
                           rsp_ff.cursor_x  <= adv_col;
                           rsp_ff.cursor_y  <= adv_row;
                           rsp_ff.cell_data <= '0;
                        end
                     end
                     OP_CLEAR: begin
                        rsp_valid_ff <= 1'b0;
                        cur_col_ff   <= '0;
                        cur_row_ff   <= '0;
                        fill_ff      <= {attr, SPACE_CODE};
                        cnt_ff       <= '0;
                        state_ff     <= S_FILL;
                     end
                     OP_SET: begin
                        cur_col_ff       <= cmd.col;
                        cur_row_ff       <= cmd.row;
                        rsp_valid_ff     <= 1'b1;
                        rsp_ff.cursor_x  <= cmd.col;
                        rsp_ff.cursor_y  <= cmd.row;
                        rsp_ff.cell_data <= '0;
                     end
                     OP_READ: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= S_READ;
                     end
                     OP_NOP: begin
                        rsp_valid_ff     <= 1'b1;
                        rsp_ff.cursor_x  <= cur_col_ff;
                        rsp_ff.cursor_y  <= cur_row_ff;
                        rsp_ff.cell_data <= '0;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= S_IDLE;
                     end
                  endcase
               end
            end
            S_READ: begin
               rsp_valid_ff     <= 1'b1;
               rsp_ff.cursor_x  <= cur_col_ff;
               rsp_ff.cursor_y  <= cur_row_ff;
               rsp_ff.cell_data <= ram_rdata;
               state_ff         <= S_IDLE;
            end
            S_SCROLL: begin
               // read one row below, write back on the next cycle
               wr_pend_ff <= 1'b1;
               wr_addr_ff <= cnt_ff;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == ADDR_W'(CELL_COUNT - COLUMNS - 1)) begin
                  fill_ff  <= '0;
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               if (wr_pend_ff) begin
                  wr_pend_ff <= 1'b0;
               end else if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
                  cnt_ff           <= '0;
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.cursor_x  <= cur_col_ff;
                  rsp_ff.cursor_y  <= cur_row_ff;
                  rsp_ff.cell_data <= '0;
                  state_ff         <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (int'(cur_row_ff) < ROWS) && (int'(cur_col_ff) < COLUMNS))
      else $error("cursor left the screen");

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> int'(ram_waddr) < CELL_COUNT)
      else $error("screen write beyond the store");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("result slot busy during a cell read");

   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == OP_READ) |=> state_ff == S_READ)
      else $error("read command did not wait for store data");

endmodule
`default_nettype wire

[sv/text_console_writer_top.sv]
// Text console writer top level: attribute register, stream packing, front and back.
// Simple commands (put char without scroll, set cursor, off-screen read) finish in the idle state
// and stream at one per cycle while the result slot is free; a cell read waits in the read state.
// A put char that scrolls copies the rows up, then blanks the bottom row; a clear fills spaces.
// rsp_tvalid follows a beat via the command queue, read state (cell read) and result register.
// Reset is synchronous: a clearing pass zeroes the store; requests wait.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // func[1:0], char_code[9:2], col[16:10], row[21:17]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // cursor_x[6:0], cursor_y[11:7], cell_data[27:12]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // text_attribute
);
   import tcw_pkg::*;

   logic [ATTR_W-1:0] attr_ff;
   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_pop;
   rsp_type           rsp;

   // attribute register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   tcw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tdata[1:0]),
      .in_char   (req_tdata[9:2]),
      .in_col    (req_tdata[16:10]),
      .in_row    (req_tdata[21:17]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .attr      (attr_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // result beat packing
   assign rsp_tdata = {4'b0, rsp.cell_data, rsp.cursor_y, rsp.cursor_x};

endmodule
`default_nettype wire

[bench/tb_text_console_writer_top.sv]
// self-checking testbench for the text console writer: predicted cursor and cells per command
`timescale 1ns / 1ps
module tb_text_console_writer_top;
   import tcw_pkg::*;

   localparam int WATCHDOG_LIMIT = 10 * CELL_COUNT;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 32;
   // settle time before an attribute write
   localparam int SWEEP_PAUSE    = CELL_COUNT + 16;

   // screen predictor plus the queue of results it expects, oldest first
   class screen_scoreboard;
      logic [CELL_W-1:0] screen [CELL_COUNT];
      logic [COL_W-1:0]  cur_col;
      logic [ROW_W-1:0]  cur_row;
      logic [ATTR_W-1:0] attr;
      rsp_type           predicted_cursor_cells [$];
      int                errors;
      int                commands;
      int                results;
      int                scrolls;
      int                clears;

      function new();
         foreach (screen[i]) screen[i] = '0;
         cur_col  = '0;
         cur_row  = '0;
         attr     = RESET_ATTR;
         errors   = 0;
         commands = 0;
         results  = 0;
         scrolls  = 0;
         clears   = 0;
      endfunction

      function void set_attribute(input logic [ATTR_W-1:0] value);
         attr = value;
      endfunction

      // rows move up by one, bottom row goes to zero
      function void scroll_screen();
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = '0;
         scrolls++;
      endfunction

      // work out the result of one accepted command beat
      function void apply_command(input logic [23:0] beat);
         func_type          f;
         logic [CHAR_W-1:0] ch;
         logic [COL_W-1:0]  c;
         logic [ROW_W-1:0]  r;
         rsp_type           res;
         f  = func_type'(beat[1:0]);
         ch = beat[9:2];
         c  = beat[16:10];
         r  = beat[21:17];
         res.cell_data = '0;
         commands++;
         case (f)
            FUNC_PUT: begin
               if (ch == NEWLINE_CODE) begin
                  cur_col = '0;
                  cur_row = cur_row + 1'b1;
               end else begin
                  screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr, ch};
                  cur_col = cur_col + 1'b1;
                  if (cur_col >= COLUMNS) begin
                     cur_col = '0;
                     cur_row = cur_row + 1'b1;
                  end
               end
               if (cur_row >= ROWS) begin
                  cur_row = ROW_W'(ROWS - 1);
                  scroll_screen();
               end
            end
            FUNC_CLEAR: begin
               foreach (screen[i]) screen[i] = {attr, SPACE_CODE};
               cur_col = '0;
               cur_row = '0;
               clears++;
            end
            FUNC_SET: begin
               cur_col = (c < COLUMNS) ? c : COL_W'(COLUMNS - 1);
               cur_row = (r < ROWS) ? r : ROW_W'(ROWS - 1);
            end
            default: begin
               if (c < COLUMNS && r < ROWS) res.cell_data = screen[int'(r) * COLUMNS + int'(c)];
            end
         endcase
         res.cursor_x = cur_col;
         res.cursor_y = cur_row;
         predicted_cursor_cells.push_back(res);
      endfunction

      // compare one result beat with the oldest prediction
      function void check_result(input logic [31:0] beat);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(beat[27:0]);
         results++;
         if (predicted_cursor_cells.size() == 0) begin
            $error("result beat 0x%08h with no command waiting", beat);
            errors++;
            return;
         end
         want = predicted_cursor_cells.pop_front();
         if (got.cursor_x !== want.cursor_x) begin
            $error("cursor_x mismatch: expected %0d, actual %0d", want.cursor_x, got.cursor_x);
            errors++;
         end
         if (got.cursor_y !== want.cursor_y) begin
            $error("cursor_y mismatch: expected %0d, actual %0d", want.cursor_y, got.cursor_y);
            errors++;
         end
         if (got.cell_data !== want.cell_data) begin
            $error("cell_data mismatch: expected 0x%04h, actual 0x%04h",
                   want.cell_data, got.cell_data);
            errors++;
         end
      endfunction

      function int pending();
         return predicted_cursor_cells.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   screen_scoreboard sb;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request  = 1'b0;
   bit  hold_taken    = 1'b0;
   int  hold_left     = 0;
   int  quiet_cycles  = 0;
   int  attr_writes   = 0;

   text_console_writer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // beat monitor and result receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.apply_command(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
      // the hold-off starts once the sender is offering beats
      if (hold_request && !hold_taken && req_tvalid) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // offer one command beat, after a random gap, and wait for it to be taken
   task automatic send_request(input func_type f, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r, c, ch, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // attribute write while the block is idle
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      repeat (SWEEP_PAUSE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_attribute(value);
      attr_writes++;
   endtask

   // random command, biased toward the bottom rows so scrolls happen often
   task automatic send_random();
      int                roll;
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  c;
      logic [ROW_W-1:0]  r;
      roll = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255));
      c    = $urandom_range(1) ? COL_W'($urandom_range(127)) : COL_W'($urandom_range(79, 70));
      r    = $urandom_range(1) ? ROW_W'($urandom_range(31)) : ROW_W'($urandom_range(24, 20));
      if (roll < 55) begin
         if ($urandom_range(15) == 0) ch = NEWLINE_CODE;
         send_request(FUNC_PUT, ch, c, r);
      end else if (roll < 70) begin
         send_request(FUNC_SET, ch, c, r);
      end else if (roll < 97) begin
         if ($urandom_range(3) != 0) begin
            c = COL_W'($urandom_range(COLUMNS - 1));
            r = ROW_W'($urandom_range(ROWS - 1));
         end
         send_request(FUNC_READ, ch, c, r);
      end else begin
         send_request(FUNC_CLEAR, ch, c, r);
      end
   endtask

   task automatic run_phase(input logic [ATTR_W-1:0] value, input int idle_pct,
                            input int stall_pct, input int count);
      write_attribute(value);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_random();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, wrap, saturation, scrolls, off-screen reads, clear
      send_request(FUNC_READ,  8'h00, 7'd0,   5'd0);
      send_request(FUNC_PUT,   8'h41, 7'd0,   5'd0);
      send_request(FUNC_READ,  8'h00, 7'd0,   5'd0);
      send_request(FUNC_SET,   8'h00, 7'd127, 5'd31);
      send_request(FUNC_PUT,   8'hFF, 7'd0,   5'd0);
      send_request(FUNC_READ,  8'h00, 7'd79,  5'd23);
      send_request(FUNC_READ,  8'h00, 7'd0,   5'd24);
      send_request(FUNC_SET,   8'h00, 7'd78,  5'd24);
      send_request(FUNC_PUT,   8'h00, 7'd0,   5'd0);
      send_request(FUNC_PUT,   NEWLINE_CODE, 7'd0, 5'd0);
      send_request(FUNC_READ,  8'h00, 7'd78,  5'd23);
      send_request(FUNC_SET,   8'h00, 7'd0,   5'd0);
      send_request(FUNC_PUT,   NEWLINE_CODE, 7'd0, 5'd0);
      send_request(FUNC_READ,  8'h00, 7'd80,  5'd0);
      send_request(FUNC_READ,  8'h00, 7'd0,   5'd25);
      send_request(FUNC_READ,  8'h00, 7'd127, 5'd31);
      send_request(FUNC_CLEAR, 8'h00, 7'd0,   5'd0);
      send_request(FUNC_READ,  8'h00, 7'd79,  5'd24);
      send_request(FUNC_SET,   8'h00, 7'd79,  5'd0);
      send_request(FUNC_PUT,   8'h42, 7'd0,   5'd0);
      send_request(FUNC_READ,  8'h00, 7'd79,  5'd0);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      // random phases; the long receiver hold-off lands in the first one
      hold_request = 1'b1;
      run_phase(8'h00, 0, 0, 140);
      run_phase(8'hFF, 80, 0, 80);
      run_phase(ATTR_W'($urandom_range(255)), 0, 80, 80);
      run_phase(8'hA5, 16, 16, 80);

      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      $display("run covered %0d commands and %0d results, %0d scrolls, %0d clears,",
               sb.commands, sb.results, sb.scrolls, sb.clears);
      $display("%0d attribute writes, idle and stall mixes, and one long receiver hold-off",
               attr_writes);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_writer_top.sv
bench/tb_text_console_writer_top.sv
